/* sv/bbe_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbe_pkg
// Shared types, constants and helpers of the edge-aware 3x3 box blur.
// ----------------------------------------------------------------------------
package bbe_pkg;

  // Default sizing of the line store and frame counters
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;

  // Register reset values and field widths
  localparam int RESET_WIDTH    = 1024;
  localparam int RESET_HEIGHT   = 768;
  localparam int FW_BITS        = 11;
  localparam int FH_BITS        = 13;
  localparam int CFG_DATA_BITS  = 13;

  // Register indexes on the configuration channel
  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  // One RGB pixel, red in the top byte
  typedef logic [23:0] rgb_t;

  // 3x3 neighbourhood, entry row*3+col, row 0 above, col 0 left
  typedef rgb_t [8:0] win_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SHIFT,
    ST_LANES,
    ST_WAIT,
    ST_OUT
  } state_t;

  // Line store / window control
  typedef struct packed {
    logic rd_en;
    logic shift;
    logic store;
  } win_ctrl_t;

  // Lane control: start strobe, in-frame mask and neighbour count
  typedef struct packed {
    logic       start;
    logic [8:0] mask;
    logic [3:0] n;
  } lane_ctrl_t;

  // floor(65535 / n): reciprocal for the mean, at most one short
  function automatic logic [15:0] recip(input logic [3:0] n);
    logic [15:0] m;
    case (n)
      4'd1:    m = 16'd65535;
      4'd2:    m = 16'd32767;
      4'd3:    m = 16'd21845;
      4'd4:    m = 16'd16383;
      4'd5:    m = 16'd13107;
      4'd6:    m = 16'd10922;
      4'd7:    m = 16'd9362;
      4'd8:    m = 16'd8191;
      4'd9:    m = 16'd7281;
      default: m = 16'd0;
    endcase
    return m;
  endfunction

endpackage

/* sv/bbe_pix_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbe_pix_if
// Pixel input channel: one raster pixel or a drain request per item.
// ----------------------------------------------------------------------------
interface bbe_pix_if ();
  logic       valid;
  logic       ready;
  logic       drain;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source (output valid, output drain, output red_in, output green_in,
                  output blue_in, input ready);
  modport sink   (input valid, input drain, input red_in, input green_in,
                  input blue_in, output ready);
endinterface

/* sv/bbe_res_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbe_res_if
// Result channel: one blurred pixel per item, flagged at frame end.
// ----------------------------------------------------------------------------
interface bbe_res_if ();
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       frame_end;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output frame_end, input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  input frame_end, output ready);
endinterface

/* sv/bbe_cfg_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbe_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface bbe_cfg_if import bbe_pkg::*; ();
  logic                     valid;
  logic                     ready;
  cfg_reg_t                 index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/bbe_window.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbe_window
// Two-row line store (one 48-bit word per column) and the 3x3 window.
// ----------------------------------------------------------------------------
module bbe_window import bbe_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  localparam int COL_BITS = $clog2(MAX_WIDTH)
) (
  input  logic                clk,
  input  logic                rst,
  input  win_ctrl_t           ctrl,
  input  logic [COL_BITS-1:0] rd_addr,
  input  rgb_t                pix,
  output win_t                window
);

  // word per column: [47:24] previous row, [23:0] the row before that
  logic [47:0]         mem [MAX_WIDTH];
  logic [47:0]         rdata;
  logic [COL_BITS-1:0] addr_q;

  // registered read, address kept for the write-back
  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rdata  <= mem[rd_addr];
      addr_q <= rd_addr;
    end
  end

  // write-back: new pixel moves in, previous row moves down
  always_ff @(posedge clk) begin
    if (ctrl.shift && ctrl.store) begin
      mem[addr_q] <= {pix, rdata[47:24]};
    end
  end

  // window shifts left, new column enters on the right
  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (ctrl.shift) begin
      for (int ro = 0; ro < 3; ro++) begin
        window[ro*3]     <= window[ro*3 + 1];
        window[ro*3 + 1] <= window[ro*3 + 2];
      end
      window[2] <= rdata[23:0];
      window[5] <= rdata[47:24];
      window[8] <= ctrl.store ? pix : '0;
    end
  end

endmodule

/* sv/bbe_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbe_lane
// One colour channel: masked 3x3 sum and rounded mean over three stages.
// ----------------------------------------------------------------------------
module bbe_lane import bbe_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  lane_ctrl_t      ctrl,
  input  logic [8:0][7:0] vals,
  output logic [7:0]      q,
  output logic            done
);

  logic [11:0] sum;
  logic [11:0] y1, y2;
  logic [3:0]  n1, n2;
  logic [27:0] prod2;
  logic        v1, v2;
  logic [7:0]  q0;
  logic [11:0] q0n;
  logic [11:0] rem;

  // sum of in-frame neighbours
  always_comb begin
    sum = '0;
    for (int k = 0; k < 9; k++) begin
      if (ctrl.mask[k]) sum = sum + 12'(vals[k]);
    end
  end

  // round half up: floor((sum + n/2) / n)
  always_comb begin
    q0  = prod2[23:16];
    q0n = 12'(q0) * 12'(n2);
    rem = y2 - q0n;
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= ctrl.start;
      v2   <= v1;
      done <= v2;
    end
  end

  // data stages, held between requests
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      y1 <= sum + 12'(ctrl.n >> 1);
      n1 <= ctrl.n;
    end
    if (v1) begin
      prod2 <= 28'(y1) * 28'(recip(n1));
      y2    <= y1;
      n2    <= n1;
    end
    if (v2) begin
      q <= (rem >= 12'(n2)) ? q0 + 8'd1 : q0;
    end
  end

endmodule

/* sv/box_blur_3x3_edge_aware.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_aware
// Edge-aware 3x3 box blur over an RGB raster stream.
//
// Pixels enter on the pixels channel in raster order; results leave on the
// results channel, each the rounded mean of the in-frame part of its 3x3
// neighbourhood. The result for pixel p comes with the request that carries
// pixel p+W+1 (W = effective width); once the frame is in, drain requests
// push out the remaining results. frame_end marks the bottom right pixel.
// cfg writes frame_width (index 0) or frame_height (index 1), restart the
// frame and are taken in any cycle.
// One request at a time under the sequencer: a drain that yields nothing
// is only accepted; a pixel without result adds the line store
// read-modify-write; a request with result adds read, window shift, the
// three-stage lane pipeline (sum, reciprocal multiply, correction) and the
// output load, the first drain of a one-row frame a further read and shift.
// The result register lets the next request in while a result waits; a
// stalled receiver holds the sequencer only at the next output load.
// Reset clears counters and window; the line store is not cleared.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_aware import bbe_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic      clk,
  input  logic      rst,
  bbe_pix_if.sink   pixels,
  bbe_res_if.source results,
  bbe_cfg_if.sink   cfg
);

  localparam int COL_BITS = $clog2(MAX_WIDTH);
  localparam int W_BITS   = $clog2(MAX_WIDTH + 1);
  localparam int ROW_BITS = $clog2(MAX_HEIGHT + 1);
  localparam int LAG_BITS = $clog2(MAX_WIDTH + 3);
  localparam int RST_W    = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
  localparam int RST_H    = (RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT;

  state_t              state, state_next;
  logic [W_BITS-1:0]   w_eff;
  logic [ROW_BITS-1:0] h_eff;
  logic [COL_BITS-1:0] in_col, scol, ocol;
  logic [ROW_BITS-1:0] in_row, orow;
  logic [LAG_BITS-1:0] lag;
  logic                item_store;
  rgb_t                item_pix;

  logic                full, store, work, in_fire, cfg_fire, out_free;
  logic                last_pos, emit_load, lanes_done;
  logic [COL_BITS-1:0] w_last;
  logic [ROW_BITS-1:0] h_last;
  logic [LAG_BITS-1:0] lag_goal, lag_inc;
  logic [31:0]         w_new, h_new;

  win_ctrl_t           win_ctrl;
  lane_ctrl_t          lane_ctrl;
  win_t                window;
  logic [2:0][7:0]     lane_q;
  logic [2:0]          lane_done;
  logic                top_ok, bot_ok, left_ok, right_ok;
  logic [2:0]          rowv, colv;
  logic [3:0]          rows_n, cols_n;

  // frame bookkeeping
  always_comb begin
    full      = (in_row == h_eff);
    store     = !pixels.drain && !full;
    work      = store || full;
    in_fire   = pixels.valid && pixels.ready;
    cfg_fire  = cfg.valid && cfg.ready;
    out_free  = !results.valid || results.ready;
    w_last    = COL_BITS'(w_eff - W_BITS'(1));
    h_last    = h_eff - ROW_BITS'(1);
    lag_goal  = LAG_BITS'(w_eff) + LAG_BITS'(2);
    lag_inc   = lag + LAG_BITS'(1);
    last_pos  = (orow == h_last) && (ocol == w_last);
    emit_load = (state == ST_OUT) && out_free;
    lanes_done = &lane_done;
  end

  // register value clamping
  always_comb begin
    w_new = 32'(cfg.data[FW_BITS-1:0]);
    h_new = 32'(cfg.data[FH_BITS-1:0]);
    if (w_new == 32'd0) w_new = 32'd1;
    if (w_new > 32'(MAX_WIDTH)) w_new = 32'(MAX_WIDTH);
    if (h_new == 32'd0) h_new = 32'd1;
    if (h_new > 32'(MAX_HEIGHT)) h_new = 32'(MAX_HEIGHT);
  end

  // in-frame neighbours of the output position
  always_comb begin
    top_ok   = (orow != '0);
    bot_ok   = ((orow + ROW_BITS'(1)) < h_eff);
    left_ok  = (ocol != '0);
    right_ok = (ocol != w_last);
    rowv     = {bot_ok, 1'b1, top_ok};
    colv     = {right_ok, 1'b1, left_ok};
    rows_n   = 4'd1 + 4'(top_ok) + 4'(bot_ok);
    cols_n   = 4'd1 + 4'(left_ok) + 4'(right_ok);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_fire && work) state_next = ST_SHIFT;
      ST_READ:  state_next = ST_SHIFT;
      ST_SHIFT: begin
        if (lag_inc == lag_goal) state_next = ST_LANES;
        else if (item_store)     state_next = ST_IDLE;
        else                     state_next = ST_READ;
      end
      ST_LANES: state_next = ST_WAIT;
      ST_WAIT:  if (lanes_done) state_next = ST_OUT;
      ST_OUT:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    pixels.ready    = (state == ST_IDLE);
    cfg.ready       = 1'b1;
    win_ctrl.rd_en  = ((state == ST_IDLE) && in_fire && work) || (state == ST_READ);
    win_ctrl.shift  = (state == ST_SHIFT);
    win_ctrl.store  = item_store;
    lane_ctrl.start = (state == ST_LANES);
    lane_ctrl.n     = rows_n * cols_n;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        lane_ctrl.mask[r*3 + c] = rowv[r] && colv[c];
      end
    end
  end

  // sequencer and position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      w_eff      <= W_BITS'(RST_W);
      h_eff      <= ROW_BITS'(RST_H);
      in_col     <= '0;
      in_row     <= '0;
      scol       <= '0;
      lag        <= '0;
      ocol       <= '0;
      orow       <= '0;
      item_store <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == ST_IDLE) && in_fire) item_store <= store;
      if (state == ST_SHIFT) begin
        scol <= (scol == w_last) ? '0 : scol + COL_BITS'(1);
        lag  <= lag_inc;
        if (item_store) begin
          if (in_col == w_last) begin
            in_col <= '0;
            in_row <= in_row + ROW_BITS'(1);
          end else begin
            in_col <= in_col + COL_BITS'(1);
          end
        end
      end
      if (emit_load) begin
        lag <= lag - LAG_BITS'(1);
        if (ocol == w_last) begin
          ocol <= '0;
          orow <= orow + ROW_BITS'(1);
        end else begin
          ocol <= ocol + COL_BITS'(1);
        end
        // frame done: start over
        if (last_pos) begin
          in_col <= '0;
          in_row <= '0;
          scol   <= '0;
          lag    <= '0;
          ocol   <= '0;
          orow   <= '0;
        end
      end
      // register write restarts the frame
      if (cfg_fire) begin
        case (cfg.index)
          REG_FRAME_WIDTH:  w_eff <= W_BITS'(w_new);
          REG_FRAME_HEIGHT: h_eff <= ROW_BITS'(h_new);
          default: ;
        endcase
        in_col <= '0;
        in_row <= '0;
        scol   <= '0;
        lag    <= '0;
        ocol   <= '0;
        orow   <= '0;
      end
    end
  end

  // latched pixel of the request in hand
  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && in_fire) begin
      item_pix <= {pixels.red_in, pixels.green_in, pixels.blue_in};
    end
  end

  // line store and window
  bbe_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (win_ctrl),
    .rd_addr (scol),
    .pix     (item_pix),
    .window  (window)
  );

  // one lane per colour channel, red first
  for (genvar ch = 0; ch < 3; ch++) begin : g_lane
    logic [8:0][7:0] vals;

    always_comb begin
      for (int k = 0; k < 9; k++) begin
        vals[k] = window[k][23 - 8*ch -: 8];
      end
    end

    bbe_lane u_lane (
      .clk  (clk),
      .rst  (rst),
      .ctrl (lane_ctrl),
      .vals (vals),
      .q    (lane_q[ch]),
      .done (lane_done[ch])
    );
  end

  // merge: result register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (emit_load) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      results.red_out   <= lane_q[0];
      results.green_out <= lane_q[1];
      results.blue_out  <= lane_q[2];
      results.frame_end <= last_pos;
    end
  end

endmodule

/* sv/bbe_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbe_checker
// Port-level checks of the box blur, bound to the top level.
// ----------------------------------------------------------------------------
module bbe_checker (
  input logic       clk,
  input logic       rst,
  input logic       pix_valid,
  input logic       pix_ready,
  input logic       pix_drain,
  input logic       res_valid,
  input logic       res_ready,
  input logic [7:0] res_red,
  input logic [7:0] res_green,
  input logic [7:0] res_blue,
  input logic       res_end
);

  // no result pending straight after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_red) && $stable(res_green)
      && $stable(res_blue) && $stable(res_end))
    else $error("stalled result changed");

  // a pixel request always moves the sequencer out of idle, holding off the input
  a_pix_busy: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix_ready && !pix_drain |=> !pix_ready)
    else $error("pixel request did not hold off the input");

  // results are loaded only while the input is held off
  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> !$past(pix_ready))
    else $error("result loaded while input open");

endmodule

bind box_blur_3x3_edge_aware bbe_checker u_bbe_checker (
  .clk       (clk),
  .rst       (rst),
  .pix_valid (pixels.valid),
  .pix_ready (pixels.ready),
  .pix_drain (pixels.drain),
  .res_valid (results.valid),
  .res_ready (results.ready),
  .res_red   (results.red_out),
  .res_green (results.green_out),
  .res_blue  (results.blue_out),
  .res_end   (results.frame_end)
);
